[src/oss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oss_pkg
// Shared types and constants for the ordered selection set.
// ----------------------------------------------------------------------------
package oss_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int ID_W     = 32;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_FLUSH  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Final update applied when a result is produced
    typedef enum logic [2:0] {
        ACT_PROMOTE = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_FULL    = 3'd2,
        ACT_REMOVE  = 3'd3,
        ACT_MISSING = 3'd4,
        ACT_CLEAR   = 3'd5,
        ACT_FLUSH   = 3'd6
    } act_t;

    typedef struct packed {
        logic load;      // capture id, restart walk pointer
        logic walk;      // read entry at pointer, advance
        logic seek;      // pointer to hit position + 1
        logic shift_wr;  // write pending read data one place down
        logic commit;    // apply act and load result register
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic walk_end;
        logic full;
        logic out_free;
    } sts_t;

endpackage : oss_pkg
`default_nettype wire

[src/oss_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oss_req_if / oss_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface oss_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [31:0]       item_id;

    modport source (output valid, kind, item_id, input ready);
    modport sink   (input valid, kind, item_id, output ready);
endinterface : oss_req_if

interface oss_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [10:0]       entry_count;
    logic              has_primary;
    logic [31:0]       primary_entity;
    logic              flushed;

    modport source (output valid, status, entry_count, has_primary, primary_entity, flushed,
                    input ready);
    modport sink   (input valid, status, entry_count, has_primary, primary_entity, flushed,
                    output ready);
endinterface : oss_rsp_if
`default_nettype wire

[src/ordered_selection_set_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_selection_set_top
// Ordered duplicate-free id list with a primary entry and a dirty flag.
// ----------------------------------------------------------------------------
// Sequence: clear and flush go from accept straight to the commit state; add and
// remove first search the N entries held, the compaction resuming at the hit.
// Throughput: one item at a time; the search and the compaction walk the id
// memory one entry per cycle through its single registered read port.
// A new beat is taken while the previous result waits on the output register.
// Reset: asynchronous, list empty, no primary, dirty flag set; no clear pass.
module ordered_selection_set_top (
    input  wire logic clk,
    input  wire logic rst_n,
    oss_req_if.sink   req,
    oss_rsp_if.source rsp
);

    oss_pkg::cmd_t cmd;
    oss_pkg::sts_t sts;

    oss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_kind  (req.kind),
        .sts       (sts),
        .cmd       (cmd)
    );

    oss_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .req_item_id        (req.item_id),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_status         (rsp.status),
        .rsp_entry_count    (rsp.entry_count),
        .rsp_has_primary    (rsp.has_primary),
        .rsp_primary_entity (rsp.primary_entity),
        .rsp_flushed        (rsp.flushed)
    );

endmodule : ordered_selection_set_top
`default_nettype wire

[src/oss_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oss_ctrl
// Sequencer: search walk, compaction walk, then commit of the result.
// ----------------------------------------------------------------------------
module oss_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire logic [1:0]    req_kind,
    input  wire oss_pkg::sts_t sts,
    output oss_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    oss_pkg::kind_t kind_reg, kind_next;
    oss_pkg::act_t  act_reg, act_next;
    logic           accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        act_next     = act_reg;
        cmd          = '0;
        cmd.act      = act_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load  = 1'b1;
                    kind_next = oss_pkg::kind_t'(req_kind);
                    case (oss_pkg::kind_t'(req_kind))
                        oss_pkg::KIND_ADD, oss_pkg::KIND_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        oss_pkg::KIND_CLEAR:
                        begin
                            act_next   = oss_pkg::ACT_CLEAR;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            act_next   = oss_pkg::ACT_FLUSH;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (kind_reg == oss_pkg::KIND_ADD)
                    begin
                        act_next   = oss_pkg::ACT_PROMOTE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.seek   = 1'b1;
                        state_next = S_SHIFT;
                    end
                end
                else if (sts.walk_end)
                begin
                    if (kind_reg == oss_pkg::KIND_ADD)
                        act_next = sts.full ? oss_pkg::ACT_FULL : oss_pkg::ACT_APPEND;
                    else
                        act_next = oss_pkg::ACT_MISSING;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.walk_end)
                begin
                    act_next   = oss_pkg::ACT_REMOVE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= oss_pkg::KIND_ADD;
            act_reg   <= oss_pkg::ACT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            act_reg   <= act_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == S_IDLE)
        else $error("commit did not end the item");

    a_shift_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> kind_reg == oss_pkg::KIND_REMOVE)
        else $error("compaction on a non-remove item");

endmodule : oss_ctrl
`default_nettype wire

[src/oss_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oss_dp
// Id memory, walk pointer, count, primary, dirty flag and result register.
// ----------------------------------------------------------------------------
module oss_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire oss_pkg::cmd_t cmd,
    output oss_pkg::sts_t      sts,
    input  wire logic [31:0]   req_item_id,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output logic [1:0]         rsp_status,
    output logic [10:0]        rsp_entry_count,
    output logic               rsp_has_primary,
    output logic [31:0]        rsp_primary_entity,
    output logic               rsp_flushed
);

    localparam oss_pkg::cnt_t CAP_CNT = oss_pkg::CNT_W'(oss_pkg::CAPACITY);

    oss_pkg::id_t   mem [oss_pkg::CAPACITY];

    oss_pkg::id_t   id_reg, id_next;
    oss_pkg::cnt_t  ptr_reg, ptr_next;
    oss_pkg::addr_t rpos_reg, rpos_next;
    logic           rvalid_reg, rvalid_next;
    oss_pkg::id_t   rdata_reg;
    oss_pkg::cnt_t  count_reg, count_next;
    logic           prim_valid_reg, prim_valid_next;
    oss_pkg::id_t   prim_id_reg, prim_id_next;
    logic           dirty_reg, dirty_next;

    logic              out_valid_reg, out_valid_next;
    oss_pkg::status_t  out_status_reg, out_status_next;
    logic              out_flushed_reg, out_flushed_next;

    logic           wr_en;
    oss_pkg::addr_t wr_addr;
    oss_pkg::id_t   wr_data;
    oss_pkg::addr_t rd_addr;
    logic           ptr_in_list;

    assign ptr_in_list  = ptr_reg < count_reg;
    assign rd_addr      = ptr_reg[oss_pkg::ADDR_W-1:0];

    assign sts.hit      = rvalid_reg && (rdata_reg == id_reg);
    assign sts.walk_end = !ptr_in_list && !rvalid_reg;
    assign sts.full     = count_reg == CAP_CNT;
    assign sts.out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        id_next          = id_reg;
        ptr_next         = ptr_reg;
        rpos_next        = rpos_reg;
        rvalid_next      = 1'b0;
        count_next       = count_reg;
        prim_valid_next  = prim_valid_reg;
        prim_id_next     = prim_id_reg;
        dirty_next       = dirty_reg;
        out_valid_next   = out_valid_reg && !rsp_ready;
        out_status_next  = out_status_reg;
        out_flushed_next = out_flushed_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[oss_pkg::ADDR_W-1:0];
        wr_data          = id_reg;

        if (cmd.load)
        begin
            id_next  = req_item_id;
            ptr_next = '0;
        end

        // Read issued this cycle returns next cycle with its position
        if (cmd.walk && ptr_in_list)
        begin
            rvalid_next = 1'b1;
            rpos_next   = ptr_reg[oss_pkg::ADDR_W-1:0];
            ptr_next    = ptr_reg + 1'b1;
        end

        if (cmd.seek)
            ptr_next = oss_pkg::CNT_W'(rpos_reg) + 1'b1;

        if (cmd.shift_wr && rvalid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rpos_reg - 1'b1;
            wr_data = rdata_reg;
        end

        if (cmd.commit)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = oss_pkg::ST_OK;
            out_flushed_next = 1'b0;
            case (cmd.act)
                oss_pkg::ACT_PROMOTE:
                begin
                    prim_valid_next = 1'b1;
                    prim_id_next    = id_reg;
                    dirty_next      = 1'b1;
                end
                oss_pkg::ACT_APPEND:
                begin
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[oss_pkg::ADDR_W-1:0];
                    wr_data         = id_reg;
                    count_next      = count_reg + 1'b1;
                    prim_valid_next = 1'b1;
                    prim_id_next    = id_reg;
                    dirty_next      = 1'b1;
                end
                oss_pkg::ACT_FULL:
                begin
                    out_status_next = oss_pkg::ST_FULL;
                end
                oss_pkg::ACT_REMOVE:
                begin
                    count_next = count_reg - 1'b1;
                    if (prim_valid_reg && (prim_id_reg == id_reg))
                    begin
                        prim_valid_next = 1'b0;
                        prim_id_next    = '0;
                    end
                    dirty_next = 1'b1;
                end
                oss_pkg::ACT_MISSING:
                begin
                    out_status_next = oss_pkg::ST_NOT_FOUND;
                end
                oss_pkg::ACT_CLEAR:
                begin
                    count_next      = '0;
                    prim_valid_next = 1'b0;
                    prim_id_next    = '0;
                    dirty_next      = 1'b1;
                end
                default:
                begin
                    out_flushed_next = dirty_reg;
                    dirty_next       = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            rvalid_reg      <= 1'b0;
            count_reg       <= '0;
            prim_valid_reg  <= 1'b0;
            prim_id_reg     <= '0;
            dirty_reg       <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg         <= ptr_next;
            rvalid_reg      <= rvalid_next;
            count_reg       <= count_next;
            prim_valid_reg  <= prim_valid_next;
            prim_id_reg     <= prim_id_next;
            dirty_reg       <= dirty_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        rpos_reg        <= rpos_next;
        out_status_reg  <= out_status_next;
        out_flushed_reg <= out_flushed_next;
    end

    // Result reflects list state after the committed update
    assign rsp_valid          = out_valid_reg;
    assign rsp_status         = out_status_reg;
    assign rsp_entry_count    = count_reg;
    assign rsp_has_primary    = prim_valid_reg;
    assign rsp_primary_entity = prim_id_reg;
    assign rsp_flushed        = out_flushed_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd.act == oss_pkg::ACT_FULL) |-> count_reg == CAP_CNT)
        else $error("full reported below capacity");

    a_flush_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && cmd.act == oss_pkg::ACT_FLUSH) |=> !dirty_reg)
        else $error("flush left dirty set");

    a_no_primary_id: assert property (@(posedge clk) disable iff (!rst_n)
        !prim_valid_reg |-> prim_id_reg == '0)
        else $error("primary id held without a primary");

endmodule : oss_dp
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ordered_selection_set_top. A table of directed
// operations runs first: empty-list cases, extreme ids, promote, remove
// at either end and of the primary, clear and flush. A fill to a long list
// then exercises long searches and the longest shifts. The random part
// works on a small pool of ids so that promotes, hits and misses are
// frequent. Every result beat is checked field by field, either against a
// value typed into the table or against a behavioral model of the set.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        oss_pkg::status_t status;
        oss_pkg::cnt_t    entry_count;
        logic             has_primary;
        oss_pkg::id_t     primary_entity;
        logic             flushed;
    } result_t;

    typedef struct {
        oss_pkg::kind_t kind;
        oss_pkg::id_t   id;
        bit             typed;
        result_t        want;
    } dir_row_t;

    localparam result_t NO_RES      = '0;
    localparam int      DIR_ROWS    = 24;
    localparam int      FILL_LEN    = 100;
    localparam int      RAND_ITEMS  = 150;
    localparam int      POOL_SIZE   = 20;
    localparam int      HOLD_CYCLES = 400;
    localparam int      MAX_PRINTS  = 40;

    // Rows with typed = 1 are checked against want, the others against the model.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{oss_pkg::KIND_FLUSH,  32'hFFFF_FFFF, 1'b1,
          '{oss_pkg::ST_OK,        11'd0, 1'b0, 32'h0, 1'b1}},
        '{oss_pkg::KIND_FLUSH,  32'h0000_0000, 1'b1,
          '{oss_pkg::ST_OK,        11'd0, 1'b0, 32'h0, 1'b0}},
        '{oss_pkg::KIND_REMOVE, 32'h0000_0005, 1'b1,
          '{oss_pkg::ST_NOT_FOUND, 11'd0, 1'b0, 32'h0, 1'b0}},
        '{oss_pkg::KIND_ADD,    32'h0000_0000, 1'b1,
          '{oss_pkg::ST_OK,        11'd1, 1'b1, 32'h0, 1'b0}},
        '{oss_pkg::KIND_ADD,    32'hFFFF_FFFF, 1'b1,
          '{oss_pkg::ST_OK,        11'd2, 1'b1, 32'hFFFF_FFFF, 1'b0}},
        '{oss_pkg::KIND_ADD,    32'h8000_0001, 1'b1,
          '{oss_pkg::ST_OK,        11'd3, 1'b1, 32'h8000_0001, 1'b0}},
        '{oss_pkg::KIND_ADD,    32'h0000_0000, 1'b1,
          '{oss_pkg::ST_OK,        11'd3, 1'b1, 32'h0, 1'b0}},
        '{oss_pkg::KIND_FLUSH,  32'h7FFF_FFFE, 1'b1,
          '{oss_pkg::ST_OK,        11'd3, 1'b1, 32'h0, 1'b1}},
        '{oss_pkg::KIND_ADD,    32'h0000_0000, 1'b0, NO_RES},
        '{oss_pkg::KIND_FLUSH,  32'h0000_0000, 1'b0, NO_RES},
        '{oss_pkg::KIND_REMOVE, 32'h1234_5678, 1'b1,
          '{oss_pkg::ST_NOT_FOUND, 11'd3, 1'b1, 32'h0, 1'b0}},
        '{oss_pkg::KIND_FLUSH,  32'hFFFF_FFFF, 1'b0, NO_RES},
        '{oss_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{oss_pkg::KIND_REMOVE, 32'h0000_0000, 1'b0, NO_RES},
        '{oss_pkg::KIND_ADD,    32'h5555_AAAA, 1'b0, NO_RES},
        '{oss_pkg::KIND_ADD,    32'hAAAA_5555, 1'b0, NO_RES},
        '{oss_pkg::KIND_REMOVE, 32'h8000_0001, 1'b0, NO_RES},
        '{oss_pkg::KIND_REMOVE, 32'hAAAA_5555, 1'b0, NO_RES},
        '{oss_pkg::KIND_REMOVE, 32'hAAAA_5555, 1'b1,
          '{oss_pkg::ST_NOT_FOUND, 11'd1, 1'b0, 32'h0, 1'b0}},
        '{oss_pkg::KIND_CLEAR,  32'hDEAD_BEEF, 1'b1,
          '{oss_pkg::ST_OK,        11'd0, 1'b0, 32'h0, 1'b0}},
        '{oss_pkg::KIND_FLUSH,  32'h0000_0000, 1'b1,
          '{oss_pkg::ST_OK,        11'd0, 1'b0, 32'h0, 1'b1}},
        '{oss_pkg::KIND_CLEAR,  32'h0000_0000, 1'b1,
          '{oss_pkg::ST_OK,        11'd0, 1'b0, 32'h0, 1'b0}},
        '{oss_pkg::KIND_FLUSH,  32'hFFFF_FFFF, 1'b1,
          '{oss_pkg::ST_OK,        11'd0, 1'b0, 32'h0, 1'b1}},
        '{oss_pkg::KIND_REMOVE, 32'h0000_0000, 1'b1,
          '{oss_pkg::ST_NOT_FOUND, 11'd0, 1'b0, 32'h0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    oss_req_if req_ch ();
    oss_rsp_if rsp_ch ();

    ordered_selection_set_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // model of the set
    oss_pkg::id_t set_ids [$];
    bit           set_prim_valid;
    oss_pkg::id_t set_prim_id;
    bit           set_dirty;

    result_t      pending_results [$];
    bit           row_typed;
    result_t      row_want;
    bit           tx_gaps;
    bit           rx_gaps;
    bit           hold_req;
    oss_pkg::id_t fill_base;
    oss_pkg::id_t id_pool [POOL_SIZE];

    int      n_errors;
    int      n_sent;
    int      n_checked;
    int      n_full;
    int      n_missing;
    int      n_flushed;
    int      max_len;

    function automatic result_t next_set_result(oss_pkg::kind_t k, oss_pkg::id_t id);
        result_t r;
        int      pos;
        r   = '0;
        pos = -1;
        foreach (set_ids[i])
            if (pos < 0 && set_ids[i] == id)
                pos = i;
        case (k)
            oss_pkg::KIND_ADD:
            begin
                if (pos >= 0 || set_ids.size() < oss_pkg::CAPACITY)
                begin
                    if (pos < 0)
                        set_ids.push_back(id);
                    set_prim_valid = 1'b1;
                    set_prim_id    = id;
                    set_dirty      = 1'b1;
                end
                else
                begin
                    r.status = oss_pkg::ST_FULL;
                    n_full++;
                end
            end
            oss_pkg::KIND_REMOVE:
            begin
                if (pos >= 0)
                begin
                    set_ids.delete(pos);
                    if (set_prim_valid && set_prim_id == id)
                    begin
                        set_prim_valid = 1'b0;
                        set_prim_id    = '0;
                    end
                    set_dirty = 1'b1;
                end
                else
                begin
                    r.status = oss_pkg::ST_NOT_FOUND;
                    n_missing++;
                end
            end
            oss_pkg::KIND_CLEAR:
            begin
                set_ids.delete();
                set_prim_valid = 1'b0;
                set_prim_id    = '0;
                set_dirty      = 1'b1;
            end
            default:
            begin
                if (set_dirty)
                begin
                    r.flushed = 1'b1;
                    set_dirty = 1'b0;
                    n_flushed++;
                end
            end
        endcase
        if (set_ids.size() > max_len)
            max_len = set_ids.size();
        r.entry_count    = oss_pkg::cnt_t'(set_ids.size());
        r.has_primary    = set_prim_valid;
        r.primary_entity = set_prim_valid ? set_prim_id : '0;
        return r;
    endfunction

    task automatic report(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("%0t MISMATCH %s", $time, msg);
    endtask

    task automatic check_result(result_t got, result_t want);
        if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d",
                             got.entry_count, want.entry_count));
        if (got.has_primary !== want.has_primary)
            report($sformatf("has_primary got %b want %b",
                             got.has_primary, want.has_primary));
        if (got.primary_entity !== want.primary_entity)
            report($sformatf("primary_entity got %h want %h",
                             got.primary_entity, want.primary_entity));
        if (got.flushed !== want.flushed)
            report($sformatf("flushed got %b want %b", got.flushed, want.flushed));
    endtask

    // Result beat is popped before the request beat of the same edge is pushed.
    always @(posedge clk)
    begin
        result_t got;
        result_t model_res;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{oss_pkg::status_t'(rsp_ch.status), rsp_ch.entry_count,
                        rsp_ch.has_primary, rsp_ch.primary_entity, rsp_ch.flushed};
                if (pending_results.size() == 0)
                    report("result beat with nothing outstanding");
                else
                    check_result(got, pending_results.pop_front());
                n_checked++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                model_res = next_set_result(oss_pkg::kind_t'(req_ch.kind), req_ch.item_id);
                pending_results.push_back(row_typed ? row_want : model_res);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (rx_gaps)
                rsp_ch.ready <= ($urandom_range(99) >= 25);
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_op(oss_pkg::kind_t k, oss_pkg::id_t id, bit typed, result_t want);
        while (tx_gaps && $urandom_range(99) < 25)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= k;
        req_ch.item_id <= id;
        row_typed      <= typed;
        row_want       <= want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        @(posedge clk);
    endtask

    // odd multiplier keeps the fill ids distinct
    function automatic oss_pkg::id_t fill_id(int i);
        return fill_base + oss_pkg::id_t'(i) * 32'h9E37_79B1;
    endfunction

    initial
    begin
        int             pick;
        oss_pkg::kind_t k;
        oss_pkg::id_t   id;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= oss_pkg::KIND_ADD;
        req_ch.item_id   <= '0;
        row_typed        <= 1'b0;
        row_want         <= NO_RES;
        tx_gaps          = 1'b1;
        rx_gaps          = 1'b1;
        hold_req         = 1'b0;
        set_ids.delete();
        set_prim_valid   = 1'b0;
        set_prim_id      = '0;
        set_dirty        = 1'b1;
        n_errors  = 0;
        n_sent    = 0;
        n_checked = 0;
        n_full    = 0;
        n_missing = 0;
        n_flushed = 0;
        max_len   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_op(dir_tab[r].kind, dir_tab[r].id, dir_tab[r].typed, dir_tab[r].want);
        wait_all_results();

        // long list, then shifts from the front and near the end and a promote in the middle
        tx_gaps   = 1'b0;
        rx_gaps   = 1'b0;
        fill_base = $urandom();
        send_op(oss_pkg::KIND_CLEAR, $urandom(), 1'b0, NO_RES);
        for (int i = 0; i < FILL_LEN; i++)
            send_op(oss_pkg::KIND_ADD, fill_id(i), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_ADD, fill_id(FILL_LEN), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_ADD, fill_id(FILL_LEN + 1), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_ADD, fill_id(FILL_LEN / 2), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_REMOVE, fill_id(FILL_LEN - 1), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_ADD, fill_id(FILL_LEN - 1), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_REMOVE, fill_id(0), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_ADD, fill_id(FILL_LEN + 2), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_ADD, fill_id(FILL_LEN + 3), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_FLUSH, $urandom(), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_REMOVE, fill_id(FILL_LEN / 2), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_REMOVE, fill_id(FILL_LEN - 1), 1'b0, NO_RES);
        send_op(oss_pkg::KIND_CLEAR, $urandom(), 1'b0, NO_RES);
        wait_all_results();

        // small id pool keeps the list short and makes hits and promotes common
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int p = 2; p < POOL_SIZE; p++)
            id_pool[p] = $urandom();
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 30)
                hold_req = 1'b1;
            if (n == 120)
                wait_all_results();
            tx_gaps = !(n >= 60 && n < 100);
            rx_gaps = tx_gaps;
            pick = $urandom_range(99);
            if ($urandom_range(9) < 8)
                id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else
                id = $urandom();
            if (pick < 42)
                k = oss_pkg::KIND_ADD;
            else if (pick < 72)
                k = oss_pkg::KIND_REMOVE;
            else if (pick < 80)
                k = oss_pkg::KIND_CLEAR;
            else
                k = oss_pkg::KIND_FLUSH;
            send_op(k, id, 1'b0, NO_RES);
        end
        wait_all_results();
        repeat (64) @(posedge clk);

        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
        $display("Run covered %0d beats in, %0d results checked, longest list %0d.",
                 n_sent, n_checked, max_len);
        $display("Full rejects %0d, remove misses %0d, flushes with dirty set %0d.",
                 n_full, n_missing, n_flushed);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // the timeout allows far more time than a full run needs
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb
